// ===== hw/rtl/rgb_sharp_pkg.sv =====
// shared constants for the rgb cross-kernel sharpening core
`default_nettype none

package rgb_sharp_pkg;

    localparam int CFG_IDX_BITS  = 1;
    localparam int CFG_DATA_BITS = 16;
    localparam int FW_BITS       = 13;
    localparam int FH_BITS       = 16;
    localparam int NUM_CHAN      = 3;

    localparam int FRAME_WIDTH_RST  = 640;
    localparam int FRAME_HEIGHT_RST = 480;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_FRAME_WIDTH  = 1'b0,
        CFG_FRAME_HEIGHT = 1'b1
    } t_cfg_idx;

endpackage

`default_nettype wire

// ===== hw/rtl/rgb_sharpen_cross_kernel_core.sv =====
// rgb sharpening core: 5*centre minus four neighbours, clamp-to-edge, two row memories
//
// Pixels arrive on the s_axis channel in raster order, one transfer per pixel,
// red in the low byte of tdata; tuser high marks a drain transfer with no pixel.
// Sharpened pixels leave on the m_axis channel; tlast marks the last pixel of a
// frame. The result for pixel (x,y) is produced by the transfer of pixel (x,y+1),
// so row 0 gives nothing; after the last pixel of a frame, frame-width drain
// transfers flush the bottom row. Drain outside a flush and pixels during a flush
// are taken and dropped.
// Throughput: one transfer per clock in both directions while m_axis is ready.
// The row memories are read into the read stage at the accepting edge, and the
// kernel result is registered into the output register when the read stage
// moves on, which raises m_axis_tvalid.
// The row memories are read-modify-write: the middle row is read at x and x+1 and
// written at x on a pixel transfer; the upper row is written as the read stage
// moves on, with a bypass onto a read in that cycle. Frame sizes come from the
// config port (index 0 width, 1 height) and reset to 640 x 480. Reset clears
// counters and flags; the row memories are not cleared. When m_axis stalls, the
// pipeline holds and s_axis_tready drops once both stages are full.
`default_nettype none

module rgb_sharpen_cross_kernel_core #(
    parameter int MAX_WIDTH    = 4096,
    parameter int CHANNEL_BITS = 8
) (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_rst_n,
    input  wire logic                                    i_cfg_we,
    input  wire logic [rgb_sharp_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  wire logic [rgb_sharp_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    input  wire logic                                    s_axis_tvalid,
    output      logic                                    s_axis_tready,
    // red_in, green_in, blue_in
    input  wire logic [((3*CHANNEL_BITS+7)/8)*8-1:0]     s_axis_tdata,
    // drain
    input  wire logic                                    s_axis_tuser,
    output      logic                                    m_axis_tvalid,
    input  wire logic                                    m_axis_tready,
    // red_out, green_out, blue_out
    output      logic [((3*CHANNEL_BITS+7)/8)*8-1:0]     m_axis_tdata,
    output      logic                                    m_axis_tlast
);

    localparam int AW  = $clog2(MAX_WIDTH);
    localparam int PW  = rgb_sharp_pkg::NUM_CHAN * CHANNEL_BITS;
    localparam int DW  = ((PW + 7) / 8) * 8;
    localparam int SW  = CHANNEL_BITS + 4;
    localparam int RST_W = (rgb_sharp_pkg::FRAME_WIDTH_RST > MAX_WIDTH) ?
                           MAX_WIDTH : rgb_sharp_pkg::FRAME_WIDTH_RST;
    localparam logic [AW-1:0] RST_LAST_COL = AW'(RST_W - 1);
    localparam logic [rgb_sharp_pkg::FH_BITS-1:0] RST_LAST_ROW =
        rgb_sharp_pkg::FH_BITS'(rgb_sharp_pkg::FRAME_HEIGHT_RST - 1);
    localparam logic [SW-1:0] CHAN_MAX = SW'((1 << CHANNEL_BITS) - 1);

    // row memories
    logic [PW-1:0] mid_mem [MAX_WIDTH];
    logic [PW-1:0] up_mem  [MAX_WIDTH];

    // control state
    logic [AW-1:0]                       r_col;
    logic [rgb_sharp_pkg::FH_BITS-1:0]   r_row;
    logic                                r_flush;
    logic                                r_flush_top;
    logic [AW-1:0]                       r_last_col;
    logic [rgb_sharp_pkg::FH_BITS-1:0]   r_last_row;
    logic [AW-1:0]                       n_last_col;
    logic [rgb_sharp_pkg::FH_BITS-1:0]   n_last_row;

    // read stage
    logic [PW-1:0] r_mid_c;
    logic [PW-1:0] r_mid_r;
    logic [PW-1:0] r_up;
    logic          r_b_valid;
    logic          r_b_prod;
    logic          r_b_wup;
    logic [AW-1:0] r_b_x;
    logic          r_b_ledge;
    logic          r_b_redge;
    logic          r_b_use_up;
    logic          r_b_drain;
    logic [PW-1:0] r_b_pix;
    logic [PW-1:0] r_left;

    // output stage
    logic          r_out_valid;
    logic [PW-1:0] r_out_data;
    logic          r_out_last;
    logic [PW-1:0] n_out_data;

    logic          acc;
    logic          eff;
    logic          drain;
    logic          right;
    logic [AW-1:0] xr;
    logic          b_move;
    logic          up_we;
    logic [PW-1:0] pix;
    logic [rgb_sharp_pkg::FW_BITS-1:0] cfg_w;
    logic [rgb_sharp_pkg::FH_BITS-1:0] cfg_h;

    assign drain  = s_axis_tuser;
    assign pix    = s_axis_tdata[PW-1:0];
    assign eff    = drain ? r_flush : !r_flush;
    assign b_move = r_b_valid && (!r_b_prod || !r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_b_valid || b_move;
    assign acc    = s_axis_tvalid && s_axis_tready;
    assign right  = (r_col >= r_last_col);
    assign xr     = right ? r_col : r_col + 1'b1;
    assign up_we  = b_move && r_b_wup;

    assign cfg_w = i_cfg_data[rgb_sharp_pkg::FW_BITS-1:0];
    assign cfg_h = i_cfg_data[rgb_sharp_pkg::FH_BITS-1:0];

    always_comb begin
        if (cfg_w < rgb_sharp_pkg::FW_BITS'(2)) begin
            n_last_col = AW'(1);
        end else if (32'(cfg_w) > 32'(MAX_WIDTH)) begin
            n_last_col = AW'(MAX_WIDTH - 1);
        end else begin
            n_last_col = AW'(cfg_w - 1'b1);
        end
        if (cfg_h < rgb_sharp_pkg::FH_BITS'(2)) begin
            n_last_row = rgb_sharp_pkg::FH_BITS'(1);
        end else begin
            n_last_row = cfg_h - 1'b1;
        end
    end

    // configuration and position counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_col  <= RST_LAST_COL;
            r_last_row  <= RST_LAST_ROW;
            r_col       <= '0;
            r_row       <= '0;
            r_flush     <= 1'b0;
            r_flush_top <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (rgb_sharp_pkg::t_cfg_idx'(i_cfg_idx))
                    rgb_sharp_pkg::CFG_FRAME_WIDTH:  r_last_col <= n_last_col;
                    rgb_sharp_pkg::CFG_FRAME_HEIGHT: r_last_row <= n_last_row;
                    default: ;
                endcase
            end
            if (acc && eff) begin
                if (right) begin
                    r_col <= '0;
                    if (drain) begin
                        r_flush <= 1'b0;
                    end else if (r_row >= r_last_row) begin
                        r_flush_top <= (r_row == '0);
                        r_row       <= '0;
                        r_flush     <= 1'b1;
                    end else begin
                        r_row <= r_row + 1'b1;
                    end
                end else begin
                    r_col <= r_col + 1'b1;
                end
            end
        end
    end

    // middle row memory: two reads, write of the new pixel (read-first)
    always_ff @(posedge i_clk) begin
        if (acc && eff) begin
            r_mid_c <= mid_mem[r_col];
            r_mid_r <= mid_mem[xr];
            if (!drain) begin
                mid_mem[r_col] <= pix;
            end
        end
    end

    // upper row memory: read with bypass of the write in the same cycle
    always_ff @(posedge i_clk) begin
        if (acc && eff) begin
            if (up_we && (r_b_x == r_col)) begin
                r_up <= r_mid_c;
            end else begin
                r_up <= up_mem[r_col];
            end
        end
        if (up_we) begin
            up_mem[r_b_x] <= r_mid_c;
        end
    end

    // read stage control and payload
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (acc) begin
            r_b_valid <= eff;
        end else if (b_move) begin
            r_b_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc && eff) begin
            r_b_prod   <= drain || (r_row != '0);
            r_b_wup    <= !drain;
            r_b_x      <= r_col;
            r_b_ledge  <= (r_col == '0);
            r_b_redge  <= right;
            r_b_use_up <= drain ? !r_flush_top : (r_row >= rgb_sharp_pkg::FH_BITS'(2));
            r_b_drain  <= drain;
            r_b_pix    <= pix;
        end
        if (b_move) begin
            r_left <= r_mid_c;
        end
    end

    // kernel per channel
    always_comb begin
        logic [SW-1:0] c;
        logic [SW-1:0] l;
        logic [SW-1:0] r;
        logic [SW-1:0] u;
        logic [SW-1:0] d;
        logic signed [SW-1:0] s;
        n_out_data = '0;
        for (int k = 0; k < rgb_sharp_pkg::NUM_CHAN; k++) begin
            c = SW'(r_mid_c[k*CHANNEL_BITS +: CHANNEL_BITS]);
            l = r_b_ledge  ? c : SW'(r_left[k*CHANNEL_BITS +: CHANNEL_BITS]);
            r = r_b_redge  ? c : SW'(r_mid_r[k*CHANNEL_BITS +: CHANNEL_BITS]);
            u = r_b_use_up ? SW'(r_up[k*CHANNEL_BITS +: CHANNEL_BITS]) : c;
            d = r_b_drain  ? c : SW'(r_b_pix[k*CHANNEL_BITS +: CHANNEL_BITS]);
            s = $signed((c << 2) + c - l - r - u - d);
            if (s < 0) begin
                n_out_data[k*CHANNEL_BITS +: CHANNEL_BITS] = '0;
            end else if (s > $signed(CHAN_MAX)) begin
                n_out_data[k*CHANNEL_BITS +: CHANNEL_BITS] = CHAN_MAX[CHANNEL_BITS-1:0];
            end else begin
                n_out_data[k*CHANNEL_BITS +: CHANNEL_BITS] = s[CHANNEL_BITS-1:0];
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (b_move && r_b_prod) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_move && r_b_prod) begin
            r_out_data <= n_out_data;
            r_out_last <= r_b_drain && r_b_redge;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = DW'(r_out_data);
    assign m_axis_tlast  = r_out_last;

endmodule

`default_nettype wire
